@@ hdl/fcsc_pkg.sv @@
// Shared constants, field layouts and bundle types for the frustum cull block.
// Used by every module under hdl/; depends on nothing else.
package fcsc_pkg;

  // Coordinate and radius formats.
  localparam int COORD_BITS = 16;
  localparam int RAD_W      = 15;
  localparam int FIELD_W    = 16;
  localparam int PLANE_W    = 4 * FIELD_W;
  localparam int PLANE_COUNT = 6;
  localparam int CFG_IDX_W  = 3;

  // Plane register layout: normal x, y, z (Q2.14) then distance (signed integer, Q16.0).
  localparam int FLD_DIST    = 3;
  localparam int NORMAL_FRAC = 14;

  // Axis extent path widths.
  localparam int NORM_BITS  = 20;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int LEN_W      = 2 * DIFF_W;
  localparam int Q_W        = NORM_BITS + 1;
  localparam int R2_W       = 2 * RAD_W;
  localparam int ROOT_W     = RAD_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = ROOT_W;

  // Plane test widths.
  localparam int BOX_W  = COORD_BITS + 2;
  localparam int PROD_W = FIELD_W + BOX_W;
  localparam int TERM_W = FIELD_W + 2;
  localparam int SUM_W  = PROD_W + 3;

  // Box corners and sphere bias handed to the plane testers.
  typedef struct packed {
    logic [2:0][BOX_W-1:0] lo;
    logic [2:0][BOX_W-1:0] hi;
    logic [RAD_W-1:0]      bias;
  } box_t;

  // Side data that travels alongside the divider and square root lanes.
  typedef struct packed {
    logic                       valid;
    logic                       cmd;
    logic                       len_zero;
    logic [RAD_W-1:0]           r;
    logic [R2_W-1:0]            r2;
    logic [2:0][COORD_BITS-1:0] lo;
    logic [2:0][COORD_BITS-1:0] hi;
  } side_t;

endpackage

@@ hdl/fcsc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage: quo = num * 2^20 / den.
// Requires num <= den. Depends on fcsc_pkg.
module fcsc_div (
  input  logic                       clk,
  input  logic [fcsc_pkg::LEN_W-1:0] num,
  input  logic [fcsc_pkg::LEN_W-1:0] den,
  output logic [fcsc_pkg::Q_W-1:0]   quo
);
  import fcsc_pkg::*;

  logic [LEN_W-1:0] rem_r   [DIV_STEPS];
  logic [LEN_W-1:0] den_r   [DIV_STEPS];
  logic [Q_W-1:0]   quo_r   [DIV_STEPS];
  logic [LEN_W-1:0] rem_nxt [DIV_STEPS];
  logic [LEN_W-1:0] den_nxt [DIV_STEPS];
  logic [Q_W-1:0]   quo_nxt [DIV_STEPS];

  // Each stage shifts the partial remainder and tries one subtraction.
  always_comb begin
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic [LEN_W-1:0] dsr;
    logic [Q_W-1:0]   qin;
    logic             ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        trial = {1'b0, num};
        dsr   = den;
        qin   = '0;
      end else begin
        trial = {rem_r[j-1], 1'b0};
        dsr   = den_r[j-1];
        qin   = quo_r[j-1];
      end
      diff       = trial - {1'b0, dsr};
      ge         = (trial >= {1'b0, dsr});
      rem_nxt[j] = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      den_nxt[j] = dsr;
      quo_nxt[j] = {qin[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      rem_r[j] <= rem_nxt[j];
      den_r[j] <= den_nxt[j];
      quo_r[j] <= quo_nxt[j];
    end
  end

  assign quo = quo_r[DIV_STEPS-1];

endmodule

@@ hdl/fcsc_sqrt.sv @@
// Pipelined integer square root, one result bit per stage (floor of sqrt).
// Depends on fcsc_pkg.
module fcsc_sqrt (
  input  logic                        clk,
  input  logic [fcsc_pkg::R2_W-1:0]   val,
  output logic [fcsc_pkg::ROOT_W-1:0] root
);
  import fcsc_pkg::*;

  logic [R2_W-1:0] v_r     [SQRT_STEPS];
  logic [R2_W-1:0] res_r   [SQRT_STEPS];
  logic [R2_W-1:0] v_nxt   [SQRT_STEPS];
  logic [R2_W-1:0] res_nxt [SQRT_STEPS];

  // Digit-by-digit method: each stage owns one power of four.
  always_comb begin
    logic [R2_W-1:0] v_in;
    logic [R2_W-1:0] res_in;
    logic [R2_W-1:0] bitv;
    logic [R2_W-1:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        v_in   = val;
        res_in = '0;
      end else begin
        v_in   = v_r[k-1];
        res_in = res_r[k-1];
      end
      bitv  = R2_W'(1) << (R2_W - 2 - 2 * k);
      trial = res_in + bitv;
      if (v_in >= trial) begin
        v_nxt[k]   = v_in - trial;
        res_nxt[k] = (res_in >> 1) + bitv;
      end else begin
        v_nxt[k]   = v_in;
        res_nxt[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      v_r[k]   <= v_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  assign root = res_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

@@ hdl/fcsc_plane.sv @@
// One plane tester: picks the box corner, forms the dot product and compares.
// Two register stages. Depends on fcsc_pkg.
module fcsc_plane (
  input  logic                         clk,
  input  logic [fcsc_pkg::PLANE_W-1:0] plane,
  input  fcsc_pkg::box_t               box,
  output logic                         pass
);
  import fcsc_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic signed [TERM_W-1:0] term_r;
  logic signed [TERM_W-1:0] term_nxt;
  logic signed [SUM_W-1:0]  sum;
  logic                     pass_r;

  // Products of the normal with the corner the normal's signs select.
  always_comb begin
    logic signed [FIELD_W-1:0] nrm;
    logic signed [BOX_W-1:0]   crn;
    logic signed [FIELD_W-1:0] dist_fld;
    for (int i = 0; i < 3; i++) begin
      nrm         = $signed(plane[FIELD_W*i +: FIELD_W]);
      crn         = nrm[FIELD_W-1] ? $signed(box.lo[i]) : $signed(box.hi[i]);
      prod_nxt[i] = PROD_W'(nrm) * PROD_W'(crn);
    end
    dist_fld = $signed(plane[FIELD_W*FLD_DIST +: FIELD_W]);
    term_nxt = $signed({{(TERM_W-RAD_W){1'b0}}, box.bias}) - TERM_W'(dist_fld);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    term_r <= term_nxt;
  end

  // Dot product minus distance plus bias must not be negative.
  assign sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
             + (SUM_W'(term_r) <<< NORMAL_FRAC);

  always_ff @(posedge clk) begin
    pass_r <= ~sum[SUM_W-1];
  end

  assign pass = pass_r;

endmodule

@@ hdl/frustum_cull_sphere_cylinder.sv @@
// Top level of the frustum cull block: plane registers, front stages, axis lanes.
// Depends on fcsc_pkg, fcsc_div, fcsc_sqrt and fcsc_plane.
//
// Usage: six plane registers are written through cfg_we / cfg_index / cfg_wdata
// (index 0..5: left, right, far, near, top, bottom; other indexes are ignored).
// A transaction is accepted at each rising edge with start high and busy low;
// busy stays low, so a new sphere or cylinder may enter in every cycle.
// Each transaction yields one result: out_valid is high for one cycle with
// out_inside_res. Throughput is one item per cycle; the latency is set by the
// 21-stage divider and the 15-stage square root that widen the cylinder's
// bounding box on each axis, plus seven stages of difference, sum, scaling,
// box, two plane test and output registers.
// Reset clears the plane registers to zero (every primitive passes) and empties
// the pipeline. The receiver cannot stall, so the pipeline never holds.
// Plane registers should be written only while no transaction is in flight.
module frustum_cull_sphere_cylinder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_x_a,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_y_a,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_z_a,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_x_b,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_y_b,
  input  logic signed [fcsc_pkg::COORD_BITS-1:0] in_z_b,
  input  logic [fcsc_pkg::RAD_W-1:0]            in_radius,
  output logic                                  out_valid,
  output logic                                  out_inside_res,
  input  logic                                  cfg_we,
  input  logic [fcsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcsc_pkg::PLANE_W-1:0]          cfg_wdata
);
  import fcsc_pkg::*;

  logic [PLANE_W-1:0] plane_r [PLANE_COUNT];

  logic                         s1_valid_r;
  logic                         s1_cmd_r;
  logic signed [COORD_BITS-1:0] s1_a_r [3];
  logic signed [COORD_BITS-1:0] s1_b_r [3];
  logic [RAD_W-1:0]             s1_r_r;

  logic [LEN_W-1:0] sq_r   [3];
  logic [LEN_W-1:0] sq_nxt [3];
  side_t            side2_r;
  side_t            side2_nxt;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [LEN_W-1:0] num_r   [3];
  logic [LEN_W-1:0] num_nxt [3];
  side_t            side3_r;

  logic [Q_W-1:0]  quo [3];
  side_t           dly1_r [DIV_STEPS];
  logic [R2_W-1:0] t_r   [3];
  logic [R2_W-1:0] t_nxt [3];
  side_t           side_t_r;

  logic [ROOT_W-1:0] root [3];
  side_t             dly2_r [SQRT_STEPS];

  box_t box_r;
  box_t box_nxt;
  logic box_valid_r;
  logic [1:0] pv_r;
  logic [PLANE_COUNT-1:0] pass;
  logic out_valid_r;
  logic out_inside_res_r;

  // Plane registers; writes beyond the six planes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PLANE_COUNT; k++) begin
        plane_r[k] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(PLANE_COUNT))) begin
      plane_r[cfg_index] <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Input stage captures the transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
    s1_cmd_r  <= in_command;
    s1_a_r[0] <= in_x_a;
    s1_a_r[1] <= in_y_a;
    s1_a_r[2] <= in_z_a;
    s1_b_r[0] <= in_x_b;
    s1_b_r[1] <= in_y_b;
    s1_b_r[2] <= in_z_b;
    s1_r_r    <= in_radius;
  end

  // Axis magnitudes, their squares, radius squared and the box extremes.
  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [LEN_W-1:0]         mag_ext;
    logic [R2_W-1:0]          r_ext;
    side2_nxt       = '0;
    side2_nxt.valid = s1_valid_r;
    side2_nxt.cmd   = s1_cmd_r;
    side2_nxt.r     = s1_r_r;
    r_ext           = R2_W'(s1_r_r);
    side2_nxt.r2    = r_ext * r_ext;
    for (int i = 0; i < 3; i++) begin
      diff      = DIFF_W'(s1_b_r[i]) - DIFF_W'(s1_a_r[i]);
      mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      mag_ext   = LEN_W'(mag);
      sq_nxt[i] = mag_ext * mag_ext;
      if (!s1_cmd_r || (s1_a_r[i] < s1_b_r[i])) begin
        side2_nxt.lo[i] = s1_a_r[i];
      end else begin
        side2_nxt.lo[i] = s1_b_r[i];
      end
      if (!s1_cmd_r || (s1_a_r[i] > s1_b_r[i])) begin
        side2_nxt.hi[i] = s1_a_r[i];
      end else begin
        side2_nxt.hi[i] = s1_b_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else begin
      side2_r.valid <= side2_nxt.valid;
    end
    side2_r.cmd      <= side2_nxt.cmd;
    side2_r.len_zero <= side2_nxt.len_zero;
    side2_r.r        <= side2_nxt.r;
    side2_r.r2       <= side2_nxt.r2;
    side2_r.lo       <= side2_nxt.lo;
    side2_r.hi       <= side2_nxt.hi;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
  end

  // Squared axis length and the per-axis numerators for the divider.
  always_comb begin
    len_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = len_nxt - sq_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else begin
      side3_r.valid <= side2_r.valid;
    end
    side3_r.cmd      <= side2_r.cmd;
    side3_r.len_zero <= (len_nxt == '0);
    side3_r.r        <= side2_r.r;
    side3_r.r2       <= side2_r.r2;
    side3_r.lo       <= side2_r.lo;
    side3_r.hi       <= side2_r.hi;
    len_r            <= len_nxt;
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= num_nxt[i];
    end
  end

  // Divider and square root lanes, one per axis.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    fcsc_div u_div (
      .clk (clk),
      .num (num_r[g]),
      .den (len_r),
      .quo (quo[g])
    );
    fcsc_sqrt u_sqrt (
      .clk  (clk),
      .val  (t_r[g]),
      .root (root[g])
    );
  end

  // Side data delay line matched to the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        dly1_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (j == 0) begin
          dly1_r[j] <= side3_r;
        end else begin
          dly1_r[j] <= dly1_r[j-1];
        end
      end
    end
  end

  // Scale the squared radius by the quotient, keeping the integer part.
  always_comb begin
    logic [R2_W+Q_W-1:0] tprod;
    for (int i = 0; i < 3; i++) begin
      tprod    = (R2_W+Q_W)'(dly1_r[DIV_STEPS-1].r2) * (R2_W+Q_W)'(quo[i]);
      t_nxt[i] = tprod[NORM_BITS +: R2_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_t_r <= '0;
    end else begin
      side_t_r <= dly1_r[DIV_STEPS-1];
    end
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= t_nxt[i];
    end
  end

  // Side data delay line matched to the square root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        dly2_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (j == 0) begin
          dly2_r[j] <= side_t_r;
        end else begin
          dly2_r[j] <= dly2_r[j-1];
        end
      end
    end
  end

  // Bounding box: cylinders widen by the extent, spheres carry the radius as bias.
  always_comb begin
    side_t                   sd;
    logic [ROOT_W-1:0]       ext;
    logic signed [BOX_W-1:0] lo_s;
    logic signed [BOX_W-1:0] hi_s;
    sd = dly2_r[SQRT_STEPS-1];
    box_nxt.bias = sd.cmd ? '0 : sd.r;
    for (int i = 0; i < 3; i++) begin
      if (!sd.cmd) begin
        ext = '0;
      end else if (sd.len_zero) begin
        ext = sd.r;
      end else begin
        ext = root[i];
      end
      lo_s = BOX_W'($signed(sd.lo[i])) - $signed(BOX_W'(ext));
      hi_s = BOX_W'($signed(sd.hi[i])) + $signed(BOX_W'(ext));
      box_nxt.lo[i] = lo_s;
      box_nxt.hi[i] = hi_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r <= 1'b0;
    end else begin
      box_valid_r <= dly2_r[SQRT_STEPS-1].valid;
    end
    box_r <= box_nxt;
  end

  // Six plane testers working in parallel.
  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
    fcsc_plane u_plane (
      .clk   (clk),
      .plane (plane_r[k]),
      .box   (box_r),
      .pass  (pass[k])
    );
  end

  // Result register: valid follows the two plane stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r        <= {pv_r[0], box_valid_r};
      out_valid_r <= pv_r[1];
    end
    out_inside_res_r <= &pass;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

endmodule
